/* design/binary_to_intel_hex_encoder_defines.svh */
// Assertion macros for the Intel HEX encoder checker.
// Included by bhex_chk.sv; depends on clk and rst_n being visible at the point of use.
`ifndef BINARY_TO_INTEL_HEX_ENCODER_DEFINES_SVH
`define BINARY_TO_INTEL_HEX_ENCODER_DEFINES_SVH

// Checked only while out of reset.
`define BHEX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BHEX_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/bhex_pkg.sv */
// Shared constants, codes, types and the hex digit function of the Intel HEX encoder.
// Used by bhex_ctrl, bhex_dp and the top level; depends on nothing.
`default_nettype none

package bhex_pkg;

    localparam int RECORD_BYTES = 16;
    localparam int FILL_W       = $clog2(RECORD_BYTES + 1);
    localparam int IDX_W        = (RECORD_BYTES > 2) ? $clog2(RECORD_BYTES) : 1;
    localparam int ADDR_W       = 32;
    localparam int CHAR_W       = 7;

    localparam logic [1:0] WORD_SHIFT_RESET = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_COLON   = 7'h3A;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'h0A;

    // Record kinds.
    localparam logic [1:0] KIND_EXT  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // Record types as they appear in the text.
    localparam logic [7:0] REC_TYPE_DATA = 8'h00;
    localparam logic [7:0] REC_TYPE_END  = 8'h01;
    localparam logic [7:0] REC_TYPE_EXT  = 8'h04;
    localparam logic [7:0] EXT_LEN       = 8'h02;

    // Position within a record.
    localparam logic [2:0] PH_COLON = 3'd0;
    localparam logic [2:0] PH_LEN   = 3'd1;
    localparam logic [2:0] PH_AHI   = 3'd2;
    localparam logic [2:0] PH_ALO   = 3'd3;
    localparam logic [2:0] PH_TYPE  = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;
    localparam logic [2:0] PH_CSUM  = 3'd6;
    localparam logic [2:0] PH_NL    = 3'd7;

    typedef struct packed {
        logic       store;     // input transaction taken this cycle
        logic       emit;      // load the output register
        logic [2:0] phase;
        logic [1:0] kind;
        logic       idx_clr;
        logic       idx_inc;
        logic       ext_done;  // record the upper address just announced
        logic       adv_addr;
        logic       clr_fill;
        logic       end_clr;   // image finished: back to the start state
        logic       run_end;
    } bhex_cmd_t;

    typedef struct packed {
        logic full;
        logic fill_nz;
        logic upper_diff;
        logic idx_last;
        logic out_free;
    } bhex_sts_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] c;
        if (nib < 4'd10) begin
            c = 7'h30 + {3'b000, nib};
        end else begin
            c = 7'h37 + {3'b000, nib};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/bhex_dp.sv */
// Datapath of the Intel HEX encoder: record buffer, fill count, addresses,
// running checksum, character generation and the output register. Uses bhex_pkg.
`default_nettype none

module bhex_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic [1:0]                    cfg_data,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          byte_valid,
    input  wire logic                          m_tready,
    input  wire bhex_pkg::bhex_cmd_t           cmd,
    output bhex_pkg::bhex_sts_t                sts,
    output logic                               m_tvalid,
    output logic [bhex_pkg::CHAR_W-1:0]        first_char,
    output logic [bhex_pkg::CHAR_W-1:0]        second_char,
    output logic                               two_chars,
    output logic                               run_end
);
    import bhex_pkg::*;

    localparam logic [FILL_W-1:0] RB_VAL = FILL_W'(RECORD_BYTES);

    logic [7:0]        buf_mem [RECORD_BYTES];
    logic [FILL_W-1:0] fill_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [15:0]       last_upper_reg;
    logic [7:0]        sum_reg;
    logic [1:0]        word_shift_reg;

    logic              m_tvalid_reg;
    logic [CHAR_W-1:0] first_reg;
    logic [CHAR_W-1:0] second_reg;
    logic              two_reg;
    logic              last_reg;

    logic [15:0]       upper;
    logic [FILL_W-1:0] nd;
    logic [FILL_W-1:0] adv;
    logic [7:0]        emit_byte;
    logic              is_byte;
    logic [CHAR_W-1:0] single_char;
    logic              do_store;

    assign upper    = addr_reg[ADDR_W-1:16];
    assign nd       = (cmd.kind == KIND_EXT) ? FILL_W'(2) : fill_reg;
    assign adv      = RB_VAL >> word_shift_reg;
    assign do_store = cmd.store && byte_valid && (fill_reg < RB_VAL);

    assign sts.full       = (fill_reg == RB_VAL);
    assign sts.fill_nz    = (fill_reg != '0);
    assign sts.upper_diff = (upper != last_upper_reg);
    assign sts.idx_last   = ((FILL_W'(idx_reg) + FILL_W'(1)) == nd);
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    // Byte or single character that the current record position shows.
    always_comb
    begin
        emit_byte   = 8'h00;
        is_byte     = 1'b1;
        single_char = CHAR_COLON;
        unique case (cmd.phase)
            PH_COLON:
            begin
                is_byte = 1'b0;
            end
            PH_LEN:
            begin
                if (cmd.kind == KIND_EXT) begin
                    emit_byte = EXT_LEN;
                end else if (cmd.kind == KIND_DATA) begin
                    emit_byte = 8'(fill_reg);
                end
            end
            PH_AHI:
            begin
                if (cmd.kind == KIND_DATA) begin
                    emit_byte = addr_reg[15:8];
                end
            end
            PH_ALO:
            begin
                if (cmd.kind == KIND_DATA) begin
                    emit_byte = addr_reg[7:0];
                end
            end
            PH_TYPE:
            begin
                if (cmd.kind == KIND_EXT) begin
                    emit_byte = REC_TYPE_EXT;
                end else if (cmd.kind == KIND_DATA) begin
                    emit_byte = REC_TYPE_DATA;
                end else begin
                    emit_byte = REC_TYPE_END;
                end
            end
            PH_DATA:
            begin
                if (cmd.kind == KIND_EXT) begin
                    emit_byte = (idx_reg == '0) ? upper[15:8] : upper[7:0];
                end else begin
                    emit_byte = buf_mem[idx_reg];
                end
            end
            PH_CSUM:
            begin
                emit_byte = ~sum_reg + 8'd1;
            end
            PH_NL:
            begin
                is_byte     = 1'b0;
                single_char = CHAR_NEWLINE;
            end
            default:
            begin
                is_byte = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_store) begin
            buf_mem[fill_reg[IDX_W-1:0]] <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_reg       <= '0;
            idx_reg        <= '0;
            addr_reg       <= '0;
            last_upper_reg <= '0;
            sum_reg        <= '0;
            word_shift_reg <= WORD_SHIFT_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                word_shift_reg <= cfg_data;
            end
            if (do_store) begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            // The checksum covers every byte from length to the last data byte.
            if (cmd.emit) begin
                if (cmd.phase == PH_COLON) begin
                    sum_reg <= '0;
                end else if (is_byte) begin
                    sum_reg <= sum_reg + emit_byte;
                end
            end
            if (cmd.ext_done) begin
                last_upper_reg <= upper;
            end
            if (cmd.adv_addr) begin
                addr_reg <= addr_reg + ADDR_W'(adv);
            end
            if (cmd.clr_fill) begin
                fill_reg <= '0;
            end
            if (cmd.end_clr) begin
                fill_reg       <= '0;
                addr_reg       <= '0;
                last_upper_reg <= '0;
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit) begin
            first_reg  <= is_byte ? hex_char(emit_byte[7:4]) : single_char;
            second_reg <= is_byte ? hex_char(emit_byte[3:0]) : '0;
            two_reg    <= is_byte;
            last_reg   <= cmd.run_end;
        end
    end

    assign m_tvalid    = m_tvalid_reg;
    assign first_char  = first_reg;
    assign second_char = second_reg;
    assign two_chars   = two_reg;
    assign run_end     = last_reg;

endmodule

`default_nettype wire

/* design/bhex_ctrl.sv */
// Controller of the Intel HEX encoder: takes input transactions and walks
// each record position by position. Uses bhex_pkg; drives bhex_dp.
`default_nettype none

module bhex_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    input  wire logic                s_tlast,
    output logic                     s_tready,
    input  wire bhex_pkg::bhex_sts_t sts,
    output bhex_pkg::bhex_cmd_t      cmd
);
    import bhex_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_EMIT   = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [1:0] kind_reg, kind_next;
    logic       end_reg, end_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        end_next     = end_reg;
        cmd          = '0;
        cmd.phase    = phase_reg;
        cmd.kind     = kind_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid) begin
                    cmd.store  = 1'b1;
                    end_next   = s_tlast;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                phase_next = PH_COLON;
                if (sts.full || (end_reg && sts.fill_nz)) begin
                    kind_next  = sts.upper_diff ? KIND_EXT : KIND_DATA;
                    state_next = S_EMIT;
                end else if (end_reg) begin
                    kind_next  = KIND_END;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    unique case (phase_reg)
                        PH_COLON: phase_next = PH_LEN;
                        PH_LEN:   phase_next = PH_AHI;
                        PH_AHI:   phase_next = PH_ALO;
                        PH_ALO:   phase_next = PH_TYPE;
                        PH_TYPE:
                        begin
                            cmd.idx_clr = 1'b1;
                            phase_next  = (kind_reg == KIND_END) ? PH_CSUM : PH_DATA;
                        end
                        PH_DATA:
                        begin
                            if (sts.idx_last) begin
                                phase_next = PH_CSUM;
                            end else begin
                                cmd.idx_inc = 1'b1;
                            end
                        end
                        PH_CSUM:  phase_next = PH_NL;
                        PH_NL:
                        begin
                            phase_next = PH_COLON;
                            if (kind_reg == KIND_EXT) begin
                                cmd.ext_done = 1'b1;
                                kind_next    = KIND_DATA;
                            end else if (kind_reg == KIND_DATA) begin
                                // A partial record keeps its address.
                                cmd.adv_addr = sts.full;
                                cmd.clr_fill = 1'b1;
                                cmd.run_end  = !end_reg;
                                state_next   = S_DECIDE;
                            end else begin
                                cmd.end_clr = 1'b1;
                                cmd.run_end = 1'b1;
                                end_next    = 1'b0;
                                state_next  = S_IDLE;
                            end
                        end
                        default: phase_next = PH_COLON;
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_COLON;
            kind_reg  <= KIND_DATA;
            end_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            end_reg   <= end_next;
        end
    end

endmodule

`default_nettype wire

/* design/binary_to_intel_hex_encoder.sv */
// Top level of the Intel HEX encoder: joins the controller and the datapath.
// Depends on bhex_pkg, bhex_ctrl and bhex_dp.
//
// Bytes of a binary image come in one per input transaction (tuser = byte
// valid, tlast = end of image) and leave as Intel HEX text, one or two
// characters per output transaction (tuser = two characters, tlast = last
// result caused by that input). Sixteen bytes fill a data record; end of image
// flushes a partial record and appends the end record. A type 04 record is
// inserted whenever the upper 16 address bits change. The block takes no new
// input until it has finished the records that the last one causes. The
// controller walks one record position per cycle into the output register;
// output stalls pause that walk. The address step per full record is
// 16 >> word_shift.
`default_nettype none

module binary_to_intel_hex_encoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data,    // word_shift
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] data_byte
    input  wire logic        s_tuser,     // byte_valid
    input  wire logic        s_tlast,     // end_of_image
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,     // [6:0] first_char, [13:7] second_char, [15:14] zero
    output logic             m_tuser,     // two_chars
    output logic             m_tlast      // run_end
);
    import bhex_pkg::*;

    bhex_cmd_t         cmd;
    bhex_sts_t         sts;
    logic [CHAR_W-1:0] first_char;
    logic [CHAR_W-1:0] second_char;

    assign cfg_ready = 1'b1;

    bhex_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bhex_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .data_byte   (s_tdata),
        .byte_valid  (s_tuser),
        .m_tready    (m_tready),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .first_char  (first_char),
        .second_char (second_char),
        .two_chars   (m_tuser),
        .run_end     (m_tlast)
    );

    assign m_tdata = {2'b00, second_char, first_char};

endmodule

`default_nettype wire

/* design/bhex_chk.sv */
// Port-level checker for the Intel HEX encoder, bound to the top level.
// Depends on binary_to_intel_hex_encoder_defines.svh.
`default_nettype none
`include "binary_to_intel_hex_encoder_defines.svh"

module bhex_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser
);

    logic [6:0] first_c;
    logic       first_hex;

    assign first_c   = m_tdata[6:0];
    assign first_hex = (first_c >= 7'h30 && first_c <= 7'h39) ||
                       (first_c >= 7'h41 && first_c <= 7'h46);

    // A reset cycle leaves the output empty on the following edge.
    `BHEX_ASSERT_ALWAYS(a_no_out_in_reset, !rst_n |=> !m_tvalid, "output valid after a reset cycle")

    `BHEX_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled output changed")

    // One item at a time: a taken transaction closes the input side.
    `BHEX_ASSERT(a_one_item, s_tvalid && s_tready |=> !s_tready, "input open right after a transaction")

    `BHEX_ASSERT(a_single_char, m_tvalid && !m_tuser |-> m_tdata[15:7] == 9'd0, "second character set on a single")

    `BHEX_ASSERT(a_hex_pair, m_tvalid && m_tuser |-> first_hex, "pair without a hex digit")

endmodule

bind binary_to_intel_hex_encoder bhex_chk u_bhex_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* sim/tb_binary_to_intel_hex_encoder.sv */
// Self-checking testbench for binary_to_intel_hex_encoder: streams image bytes in,
// predicts the Intel HEX text they produce and checks every output transaction.
// Depends on bhex_pkg and the encoder RTL only.

module tb_binary_to_intel_hex_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import bhex_pkg::*;

    localparam int unsigned SETTLE_CYCLES  = 10;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned PHASE_ITEMS    = 15;
    localparam int unsigned TIMEOUT_NS     = 5_000_000;

    typedef struct packed {
        logic [CHAR_W-1:0] first;
        logic [CHAR_W-1:0] second;
        logic              pair;
        logic              run_end;
    } hex_char_t;

    // Predicts the text of the encoder and holds the characters still owed by it.
    class hex_text_scoreboard;
        logic [7:0]  image_bytes [RECORD_BYTES];
        int unsigned bytes_held;
        logic [31:0] load_addr;
        logic [15:0] upper_sent;
        logic [1:0]  word_shift;
        logic [7:0]  record_sum;
        hex_char_t   owed_q [$];
        int unsigned mismatches = 0;

        function void clear_image();
            bytes_held = 0;
            load_addr  = '0;
            upper_sent = '0;
            record_sum = '0;
        endfunction

        function void set_shift(input logic [1:0] value);
            word_shift = value;
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction

        function logic [CHAR_W-1:0] digit(input logic [3:0] nib);
            string digits;
            digits = "0123456789ABCDEF";
            return CHAR_W'(digits[nib]);
        endfunction

        function void push(input logic [CHAR_W-1:0] c1, input logic [CHAR_W-1:0] c2,
                           input logic pair);
            hex_char_t ch;
            ch.first   = c1;
            ch.second  = c2;
            ch.pair    = pair;
            ch.run_end = 1'b0;
            owed_q.push_back(ch);
        endfunction

        function void push_hex(input logic [7:0] b);
            push(digit(b[7:4]), digit(b[3:0]), 1'b1);
        endfunction

        function void open_record(input logic [7:0] len, input logic [15:0] addr16,
                                  input logic [7:0] rec_type);
            push(CHAR_COLON, '0, 1'b0);
            push_hex(len);
            push_hex(addr16[15:8]);
            push_hex(addr16[7:0]);
            push_hex(rec_type);
            record_sum = len + addr16[15:8] + addr16[7:0] + rec_type;
        endfunction

        function void record_byte(input logic [7:0] b);
            push_hex(b);
            record_sum = record_sum + b;
        endfunction

        function void close_record();
            logic [7:0] csum;
            csum = 8'd0 - record_sum;
            push_hex(csum);
            push(CHAR_NEWLINE, '0, 1'b0);
        endfunction

        function void emit_data_record();
            logic [15:0] upper;
            int unsigned i;
            upper = load_addr[31:16];
            if (upper != upper_sent) begin
                open_record(EXT_LEN, 16'h0000, REC_TYPE_EXT);
                record_byte(upper[15:8]);
                record_byte(upper[7:0]);
                close_record();
                upper_sent = upper;
            end
            open_record(8'(bytes_held), load_addr[15:0], REC_TYPE_DATA);
            for (i = 0; i < bytes_held; i++)
            begin
                record_byte(image_bytes[i]);
            end
            close_record();
        endfunction

        // Called once per accepted input transaction.
        function void note_item(input logic [7:0] data, input logic byte_valid,
                                input logic end_of_image);
            int unsigned owed_before;
            owed_before = owed_q.size();
            if (byte_valid && bytes_held < RECORD_BYTES) begin
                image_bytes[bytes_held] = data;
                bytes_held++;
            end
            if (bytes_held >= RECORD_BYTES) begin
                emit_data_record();
                load_addr  = load_addr + 32'(RECORD_BYTES >> word_shift);
                bytes_held = 0;
            end
            if (end_of_image) begin
                if (bytes_held > 0) begin
                    emit_data_record();
                end
                open_record(8'h00, 16'h0000, REC_TYPE_END);
                close_record();
                clear_image();
            end
            if (owed_q.size() > owed_before) begin
                owed_q[owed_q.size() - 1].run_end = 1'b1;
            end
        endfunction

        // Called once per accepted output transaction.
        function void check_result(input logic [CHAR_W-1:0] c1, input logic [CHAR_W-1:0] c2,
                                   input logic pair, input logic run_end,
                                   input logic [1:0] pad);
            hex_char_t want;
            if (owed_q.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected output: first=%h second=%h two=%b last=%b",
                             c1, c2, pair, run_end);
                end
                mismatches++;
            end else begin
                want = owed_q.pop_front();
                if (c1 !== want.first || c2 !== want.second || pair !== want.pair ||
                    run_end !== want.run_end || pad !== 2'b00) begin
                    if (mismatches < 10) begin
                        $display("mismatch: expected first=%h second=%h two=%b last=%b",
                                 want.first, want.second, want.pair, want.run_end);
                        $display("          actual   first=%h second=%h two=%b last=%b pad=%b",
                                 c1, c2, pair, run_end, pad);
                    end
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;    // [7:0] data_byte
    logic        s_tuser   = 1'b0;  // byte_valid
    logic        s_tlast   = 1'b0;  // end_of_image
    logic        m_tvalid;
    logic        m_tready  = 1'b1;
    logic [15:0] m_tdata;           // [6:0] first_char, [13:7] second_char, [15:14] zero
    logic        m_tuser;           // two_chars
    logic        m_tlast;           // run_end

    hex_text_scoreboard sb;

    // Sender and receiver idling controls.
    logic        tx_gaps       = 1'b1;
    int unsigned tx_burst_left = 0;
    logic        rx_stalls     = 1'b1;
    logic        hold_request  = 1'b0;
    int unsigned hold_left     = 0;
    logic        rx_on         = 1'b1;
    int unsigned rx_run        = 0;

    binary_to_intel_hex_encoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: alternating ready and stall runs of random length, a long hold-off, or always ready.
    always @(posedge clk)
    begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (rx_stalls) begin
            if (rx_run == 0) begin
                rx_on  = !rx_on;
                rx_run = rx_on ? $urandom_range(1, 8) : $urandom_range(1, 4);
            end
            rx_run--;
            m_tready <= rx_on;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready) begin
            sb.check_result(m_tdata[6:0], m_tdata[13:7], m_tuser, m_tlast, m_tdata[15:14]);
        end
    end

    task automatic send_item(input logic [7:0] data, input logic byte_valid,
                             input logic end_of_image);
        if (tx_gaps && tx_burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            tx_burst_left = $urandom_range(1, 12);
        end
        if (tx_burst_left > 0) begin
            tx_burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= byte_valid;
        s_tlast  <= end_of_image;
        do @(posedge clk); while (!s_tready);
        sb.note_item(data, byte_valid, end_of_image);
    endtask

    // Waits until every owed character has arrived and the block has gone quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_word_shift(input logic [1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.set_shift(value);
        cfg_valid <= 1'b0;
    endtask

    // Random images of random length, with stray bare markers between bytes.
    task automatic run_images(input int unsigned item_goal);
        int unsigned sent;
        int unsigned image_len;
        int unsigned k;
        logic        end_on_byte;
        sent = 0;
        while (sent < item_goal)
        begin
            image_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                      : $urandom_range(1, 24);
            end_on_byte = ($urandom_range(0, 1) == 1) && image_len > 0;
            for (k = 0; k < image_len; k++)
            begin
                if ($urandom_range(0, 11) == 0) begin
                    send_item(8'($urandom), 1'b0, 1'b0);
                end
                send_item(8'($urandom), 1'b1, end_on_byte && (k == image_len - 1));
                sent++;
            end
            if (!end_on_byte) begin
                send_item(8'($urandom), 1'b0, 1'b1);
                sent++;
            end
        end
    endtask

    initial
    begin
        int unsigned i;
        sb = new();
        sb.clear_image();
        sb.set_shift(WORD_SHIFT_RESET);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bare marker, lone end, a short partial image ending on a byte,
        // then a full record whose last byte also ends the image.
        send_item(8'h3C, 1'b0, 1'b0);
        send_item(8'hC3, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b1);
        for (i = 0; i < RECORD_BYTES; i++)
        begin
            send_item({i[3:0], ~i[3:0]}, 1'b1, i == RECORD_BYTES - 1);
        end
        settle();

        program_word_shift(2'd3);
        run_images(PHASE_ITEMS);
        settle();

        // The receiver holds off while items keep coming, so the block backs up.
        program_word_shift(2'd0);
        tx_gaps      = 1'b0;
        hold_request = 1'b1;
        run_images(PHASE_ITEMS);
        settle();

        program_word_shift(2'd1);
        tx_gaps   = 1'b1;
        rx_stalls = 1'b0;
        run_images(PHASE_ITEMS);
        settle();

        program_word_shift(2'd2);
        rx_stalls = 1'b1;
        run_images(PHASE_ITEMS);
        settle();

        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
